// ===== hdl/blc_pkg.sv =====
// Shared types, constants and helpers for the brace nesting lexer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package blc_pkg;

  // Width of the internal nesting level (signed) and of the routine counter.
  localparam int LEVEL_BITS = 8;
  localparam int COUNT_BITS = 16;

  // Fixed widths of the result fields.
  localparam int LEVEL_OUT_BITS = 8;
  localparam int REPORT_BITS    = 17;
  localparam int LEX_BITS       = 3;

  localparam int LEVEL_EXT_BITS = (LEVEL_BITS > LEVEL_OUT_BITS) ? LEVEL_BITS : LEVEL_OUT_BITS;
  localparam int COUNT_EXT_BITS = (COUNT_BITS > REPORT_BITS) ? COUNT_BITS : REPORT_BITS;

  // Character codes of interest.
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_END    = 8'h1A;

  // Reported lexical mode codes.
  localparam logic [LEX_BITS-1:0] LEX_CODE    = 3'd0;
  localparam logic [LEX_BITS-1:0] LEX_SQUOTE  = 3'd1;
  localparam logic [LEX_BITS-1:0] LEX_DQUOTE  = 3'd2;
  localparam logic [LEX_BITS-1:0] LEX_SLASH   = 3'd3;
  localparam logic [LEX_BITS-1:0] LEX_COMMENT = 3'd4;
  localparam logic [LEX_BITS-1:0] LEX_CSTAR   = 3'd5;

  // Character class produced by the front end.
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_SQUOTE,
    CLS_DQUOTE,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_SLASH,
    CLS_STAR,
    CLS_END
  } blc_class_e;

  // Lexer state, one-hot.
  typedef enum logic [5:0] {
    MODE_CODE    = 6'b000001,
    MODE_SQUOTE  = 6'b000010,
    MODE_DQUOTE  = 6'b000100,
    MODE_SLASH   = 6'b001000,
    MODE_COMMENT = 6'b010000,
    MODE_CSTAR   = 6'b100000
  } blc_mode_e;

  // Fill status of the class queue.
  typedef struct packed {
    logic empty;
    logic full;
  } blc_qstat_t;

  function automatic blc_class_e classify(input logic [7:0] c);
    blc_class_e k;
    case (c)
      CH_SQUOTE: k = CLS_SQUOTE;
      CH_DQUOTE: k = CLS_DQUOTE;
      CH_OPEN:   k = CLS_OPEN;
      CH_CLOSE:  k = CLS_CLOSE;
      CH_SLASH:  k = CLS_SLASH;
      CH_STAR:   k = CLS_STAR;
      CH_END:    k = CLS_END;
      default:   k = CLS_OTHER;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/blc_front.sv =====
// Front end: accepts text words, classifies each byte and holds the class
// until the class queue takes it. Depends on blc_pkg.
`default_nettype none

module blc_front import blc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output blc_class_e q_cls_o
);

  logic       valid_q, valid_d;
  blc_class_e cls_q, cls_d;
  logic       accept;

  assign q_push_o = valid_q && !q_full_i;
  assign full     = valid_q && q_full_i;
  assign accept   = push && !full;
  assign q_cls_o  = cls_q;

  always_comb begin
    valid_d = valid_q;
    cls_d   = cls_q;
    if (accept) begin
      valid_d = 1'b1;
      cls_d   = classify(text_byte_i);
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
  end

endmodule

`default_nettype wire

// ===== hdl/blc_queue.sv =====
// Two-entry class queue between front and back end.
// Depends on blc_pkg.
`default_nettype none

module blc_queue import blc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  blc_class_e cls_i,
  input  logic       pop_i,
  output blc_class_e cls_o,
  output blc_qstat_t stat_o
);

  blc_class_e  mem_q [2];
  logic        wptr_q, wptr_d;
  logic        rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_push, do_pop;

  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cls_o        = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cls_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/blc_back.sv =====
// Back end: lexer state machine, nesting level, routine counter and a
// two-entry result queue. Depends on blc_pkg.
`default_nettype none

module blc_back import blc_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  blc_qstat_t                     q_stat_i,
  input  blc_class_e                     q_cls_i,
  output logic                           q_pop_o,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [LEVEL_OUT_BITS-1:0] nest_level_o,
  output logic [LEX_BITS-1:0]            lex_mode_o,
  output logic                           routine_closed_o,
  output logic                           text_done_o,
  output logic                           balanced_o,
  output logic signed [REPORT_BITS-1:0]  routines_reported_o
);

  typedef struct packed {
    logic signed [LEVEL_OUT_BITS-1:0] level;
    logic [LEX_BITS-1:0]              lex;
    logic                             closed;
    logic                             done;
    logic                             bal;
    logic signed [REPORT_BITS-1:0]    rep;
  } blc_res_t;

  localparam logic signed [LEVEL_BITS-1:0] LVL_MAX = {1'b0, {(LEVEL_BITS-1){1'b1}}};
  localparam logic signed [LEVEL_BITS-1:0] LVL_MIN = {1'b1, {(LEVEL_BITS-1){1'b0}}};
  localparam logic signed [LEVEL_BITS-1:0] LVL_ONE = LEVEL_BITS'(1);
  localparam logic [COUNT_BITS-1:0]        CNT_MAX = '1;
  localparam logic signed [LEVEL_EXT_BITS-1:0] SHOW_MAX = LEVEL_EXT_BITS'(127);
  localparam logic signed [LEVEL_EXT_BITS-1:0] SHOW_MIN = -LEVEL_EXT_BITS'(128);
  localparam logic [COUNT_EXT_BITS-1:0]    REP_CAP = COUNT_EXT_BITS'(65535);

  blc_mode_e                    mode_q, mode_d;
  logic signed [LEVEL_BITS-1:0] level_q, level_d;
  logic [COUNT_BITS-1:0]        count_q, count_d;

  blc_res_t   res_q [2];
  blc_res_t   res_d;
  logic       wptr_q, rptr_q;
  logic [1:0] rcnt_q, rcnt_d;
  logic       out_pop;

  logic                             brace;
  logic                             closed;
  logic signed [LEVEL_EXT_BITS-1:0] lvl_ext;
  logic [COUNT_EXT_BITS-1:0]        cnt_ext;

  // Take a class when the result queue has room, also when it drains now.
  assign out_pop = pop && !empty;
  assign empty   = (rcnt_q == 2'd0);
  assign q_pop_o = !q_stat_i.empty && ((rcnt_q != 2'd2) || out_pop);

  // Lexer transition; brace marks a byte that is examined for braces.
  always_comb begin
    mode_d = mode_q;
    brace  = 1'b0;
    unique case (mode_q)
      MODE_CODE: begin
        case (q_cls_i)
          CLS_SQUOTE: mode_d = MODE_SQUOTE;
          CLS_DQUOTE: mode_d = MODE_DQUOTE;
          CLS_SLASH:  mode_d = MODE_SLASH;
          default:    brace  = 1'b1;
        endcase
      end
      MODE_SQUOTE: begin
        if (q_cls_i == CLS_SQUOTE) mode_d = MODE_CODE;
      end
      MODE_DQUOTE: begin
        if (q_cls_i == CLS_DQUOTE) mode_d = MODE_CODE;
      end
      MODE_SLASH: begin
        if (q_cls_i == CLS_STAR) begin
          mode_d = MODE_COMMENT;
        end else begin
          mode_d = MODE_CODE;
          brace  = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (q_cls_i == CLS_STAR) mode_d = MODE_CSTAR;
      end
      MODE_CSTAR: begin
        if (q_cls_i == CLS_SLASH) mode_d = MODE_CODE;
        else if (q_cls_i != CLS_STAR) mode_d = MODE_COMMENT;
      end
      default: mode_d = MODE_CODE;
    endcase

    // Saturating level and routine count.
    level_d = level_q;
    count_d = count_q;
    closed  = 1'b0;
    if (brace && (q_cls_i == CLS_OPEN) && (level_q != LVL_MAX)) begin
      level_d = level_q + LVL_ONE;
    end else if (brace && (q_cls_i == CLS_CLOSE) && (level_q != LVL_MIN)) begin
      level_d = level_q - LVL_ONE;
      if (level_q == LVL_ONE) begin
        closed = 1'b1;
        if (count_q != CNT_MAX) count_d = count_q + COUNT_BITS'(1);
      end
    end

    lvl_ext = LEVEL_EXT_BITS'(level_q);
    cnt_ext = COUNT_EXT_BITS'(count_q);

    res_d.closed = closed;
    res_d.done   = 1'b0;
    res_d.bal    = 1'b0;
    res_d.rep    = '0;

    if (q_cls_i == CLS_END) begin
      // End of text: report, show the final level, drop back to reset state.
      mode_d       = MODE_CODE;
      level_d      = '0;
      count_d      = '0;
      res_d.closed = 1'b0;
      res_d.done   = 1'b1;
      res_d.bal    = (level_q == '0);
      if (cnt_ext == '0) begin
        res_d.rep = '1;
      end else if (cnt_ext >= REP_CAP) begin
        res_d.rep = REPORT_BITS'(65534);
      end else begin
        res_d.rep = REPORT_BITS'(cnt_ext - COUNT_EXT_BITS'(1));
      end
    end else begin
      lvl_ext = LEVEL_EXT_BITS'(level_d);
    end

    if (lvl_ext > SHOW_MAX) begin
      res_d.level = LEVEL_OUT_BITS'(SHOW_MAX);
    end else if (lvl_ext < SHOW_MIN) begin
      res_d.level = LEVEL_OUT_BITS'(SHOW_MIN);
    end else begin
      res_d.level = LEVEL_OUT_BITS'(lvl_ext);
    end

    unique case (mode_d)
      MODE_CODE:    res_d.lex = LEX_CODE;
      MODE_SQUOTE:  res_d.lex = LEX_SQUOTE;
      MODE_DQUOTE:  res_d.lex = LEX_DQUOTE;
      MODE_SLASH:   res_d.lex = LEX_SLASH;
      MODE_COMMENT: res_d.lex = LEX_COMMENT;
      MODE_CSTAR:   res_d.lex = LEX_CSTAR;
      default:      res_d.lex = LEX_CODE;
    endcase

    rcnt_d = rcnt_q + {1'b0, q_pop_o} - {1'b0, out_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_CODE;
      level_q <= '0;
      count_q <= '0;
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      rcnt_q  <= 2'd0;
    end else begin
      if (q_pop_o) begin
        mode_q  <= mode_d;
        level_q <= level_d;
        count_q <= count_d;
      end
      wptr_q <= wptr_q ^ q_pop_o;
      rptr_q <= rptr_q ^ out_pop;
      rcnt_q <= rcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q[wptr_q] <= res_d;
    end
  end

  assign nest_level_o        = res_q[rptr_q].level;
  assign lex_mode_o          = res_q[rptr_q].lex;
  assign routine_closed_o    = res_q[rptr_q].closed;
  assign text_done_o         = res_q[rptr_q].done;
  assign balanced_o          = res_q[rptr_q].bal;
  assign routines_reported_o = res_q[rptr_q].rep;

endmodule

`default_nettype wire

// ===== hdl/brace_nesting_lexer.sv =====
// Top level of the brace nesting lexer: front end, class queue, back end.
// Depends on blc_pkg, blc_front, blc_queue and blc_back.
// Usage
//   Input side is a queue write port: drive text_byte_i and raise push; the
//   word is taken at a rising edge where push is high and full is low.
//   Result side is a queue read port: while empty is low the oldest result
//   sits on the result ports; it is taken at an edge where pop is high.
//   Exactly one result word follows each input word, in order.
// Timing
//   A word passes the classify register, the class queue and the result
//   queue before its result shows. Throughput is one word per cycle while
//   pop stays high, set by the per-word state update in the back end.
// Stalls
//   When pop is held low the two-entry result queue fills, the back end
//   stops draining the class queue, and full rises once the front register
//   and class queue are occupied; no word is lost or repeated.
// Reset
//   rst_ni clears all queues and returns the lexer to plain code, level
//   zero and routine count zero. Byte 26 ends the text and does the same
//   after reporting balance and the routine count minus one.
`default_nettype none

module brace_nesting_lexer import blc_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       text_byte_i,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [LEVEL_OUT_BITS-1:0] nest_level_o,
  output logic [LEX_BITS-1:0]              lex_mode_o,
  output logic                             routine_closed_o,
  output logic                             text_done_o,
  output logic                             balanced_o,
  output logic signed [REPORT_BITS-1:0]    routines_reported_o
);

  logic       q_push;
  blc_class_e q_cls_in;
  blc_class_e q_cls_out;
  logic       q_pop;
  blc_qstat_t q_stat;

  // Classify and hold one word.
  blc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .text_byte_i (text_byte_i),
    .q_full_i    (q_stat.full),
    .q_push_o    (q_push),
    .q_cls_o     (q_cls_in)
  );

  // Decouple front and back so each may stall on its own.
  blc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cls_i  (q_cls_in),
    .pop_i  (q_pop),
    .cls_o  (q_cls_out),
    .stat_o (q_stat)
  );

  // Advance the lexer and queue results.
  blc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_stat_i            (q_stat),
    .q_cls_i             (q_cls_out),
    .q_pop_o             (q_pop),
    .empty               (empty),
    .pop                 (pop),
    .nest_level_o        (nest_level_o),
    .lex_mode_o          (lex_mode_o),
    .routine_closed_o    (routine_closed_o),
    .text_done_o         (text_done_o),
    .balanced_o          (balanced_o),
    .routines_reported_o (routines_reported_o)
  );

`ifndef SYNTHESIS
  // End of text always reports plain code and no routine close.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && text_done_o) |-> (lex_mode_o == LEX_CODE && !routine_closed_o))
    else $error("end of text word carries wrong mode or close flag");

  // A routine close leaves the level at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && routine_closed_o) |-> (nest_level_o == '0))
    else $error("routine close with nonzero level");

  // Report fields stay clear outside end of text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !text_done_o) |-> (!balanced_o && routines_reported_o == '0))
    else $error("report fields set before end of text");

  // The back end never drains an empty class queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("class queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking bench for brace_nesting_lexer: directed table, then random C-like text.
// Needs blc_pkg and the lexer RTL; a local predictor or a hand-typed table result checks every result word.
`timescale 1ns / 1ps

module testbench import blc_pkg::*;;

  // One result word as the block presents it on its result ports.
  typedef struct packed {
    logic signed [LEVEL_OUT_BITS-1:0] level;
    logic [LEX_BITS-1:0]              mode;
    logic                             closed;
    logic                             done;
    logic                             bal;
    logic signed [REPORT_BITS-1:0]    rep;
  } lex_word_t;

  // Directed row: the byte, and a hand-typed result where one is given.
  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    lex_word_t  want;
  } text_row_t;

  localparam logic signed [LEVEL_BITS-1:0] LVL_TOP = LEVEL_BITS'(2 ** (LEVEL_BITS - 1) - 1);
  localparam logic signed [LEVEL_BITS-1:0] LVL_BOT = LEVEL_BITS'(-(2 ** (LEVEL_BITS - 1)));
  localparam int ROWS = 24;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             push = 1'b0;
  logic                             full;
  logic [7:0]                       text_byte_i = 8'h00;
  logic                             empty;
  logic                             pop = 1'b0;
  logic signed [LEVEL_OUT_BITS-1:0] nest_level_o;
  logic [LEX_BITS-1:0]              lex_mode_o;
  logic                             routine_closed_o;
  logic                             text_done_o;
  logic                             balanced_o;
  logic signed [REPORT_BITS-1:0]    routines_reported_o;

  // Predictor state: lexical mode, nesting level and routine count.
  logic [LEX_BITS-1:0]          lex_q = LEX_CODE;
  logic signed [LEVEL_BITS-1:0] nest_q = '0;
  logic [COUNT_BITS-1:0]        routines_q = '0;

  lex_word_t pending_words[$];
  int        n_errors = 0;
  int        send_idle_pct = 0;
  int        pop_stall_pct = 0;

  // Bytes after reset, through quotes, comments, the lone slash and three ends of text.
  text_row_t text_rows [ROWS] = '{
    '{8'h78,     1'b1, '{8'sd0,  LEX_CODE, 1'b0, 1'b0, 1'b0, 17'sd0}},
    '{CH_OPEN,   1'b1, '{8'sd1,  LEX_CODE, 1'b0, 1'b0, 1'b0, 17'sd0}},
    '{CH_CLOSE,  1'b1, '{8'sd0,  LEX_CODE, 1'b1, 1'b0, 1'b0, 17'sd0}},
    '{CH_CLOSE,  1'b0, '0},
    '{CH_SQUOTE, 1'b0, '0},
    '{CH_OPEN,   1'b0, '0},
    '{CH_SQUOTE, 1'b0, '0},
    '{CH_DQUOTE, 1'b0, '0},
    '{CH_END,    1'b1, '{-8'sd1, LEX_CODE, 1'b0, 1'b1, 1'b0, 17'sd0}},
    '{CH_SLASH,  1'b0, '0},
    '{CH_OPEN,   1'b0, '0},
    '{CH_SLASH,  1'b0, '0},
    '{CH_STAR,   1'b0, '0},
    '{CH_CLOSE,  1'b0, '0},
    '{CH_STAR,   1'b0, '0},
    '{CH_STAR,   1'b0, '0},
    '{CH_SLASH,  1'b0, '0},
    '{CH_SLASH,  1'b0, '0},
    '{CH_SQUOTE, 1'b0, '0},
    '{CH_CLOSE,  1'b0, '0},
    '{8'hFF,     1'b0, '0},
    '{8'h00,     1'b0, '0},
    '{CH_END,    1'b1, '{8'sd0,  LEX_CODE, 1'b0, 1'b1, 1'b1, 17'sd0}},
    '{CH_END,    1'b1, '{8'sd0,  LEX_CODE, 1'b0, 1'b1, 1'b1, -17'sd1}}
  };

  brace_nesting_lexer u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .text_byte_i         (text_byte_i),
    .empty               (empty),
    .pop                 (pop),
    .nest_level_o        (nest_level_o),
    .lex_mode_o          (lex_mode_o),
    .routine_closed_o    (routine_closed_o),
    .text_done_o         (text_done_o),
    .balanced_o          (balanced_o),
    .routines_reported_o (routines_reported_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply a brace to the level; return 1 when a close brings it back to zero.
  function automatic logic brace_step(input logic [7:0] ch);
    logic hit;
    hit = 1'b0;
    if (ch == CH_OPEN) begin
      if (nest_q != LVL_TOP) nest_q = nest_q + LEVEL_BITS'(1);
    end else if (ch == CH_CLOSE) begin
      // A close at the bottom holds the level and closes nothing.
      if (nest_q != LVL_BOT) begin
        nest_q = nest_q - LEVEL_BITS'(1);
        if (nest_q == 0) begin
          if (routines_q != '1) routines_q = routines_q + 1'b1;
          hit = 1'b1;
        end
      end
    end
    return hit;
  endfunction

  // Advance the lexer by one byte and return the word it should produce.
  function automatic lex_word_t lex_predict(input logic [7:0] ch);
    lex_word_t w;
    longint    left;
    int        shown;
    w = '0;
    if (ch == CH_END) begin
      // End of text wins in every mode, inside quotes and comments too.
      w.done = 1'b1;
      w.bal  = (nest_q == 0);
      left   = longint'(routines_q) - 1;
      if (left > 65534) left = 65534;
      w.rep  = left[REPORT_BITS-1:0];
    end else begin
      case (lex_q)
        LEX_CODE: begin
          if (ch == CH_SQUOTE) lex_q = LEX_SQUOTE;
          else if (ch == CH_DQUOTE) lex_q = LEX_DQUOTE;
          else if (ch == CH_SLASH) lex_q = LEX_SLASH;
          else w.closed = brace_step(ch);
        end
        LEX_SQUOTE: if (ch == CH_SQUOTE) lex_q = LEX_CODE;
        LEX_DQUOTE: if (ch == CH_DQUOTE) lex_q = LEX_CODE;
        LEX_SLASH: begin
          // After a lone slash only braces count; quotes and slashes start nothing.
          if (ch == CH_STAR) begin
            lex_q = LEX_COMMENT;
          end else begin
            lex_q    = LEX_CODE;
            w.closed = brace_step(ch);
          end
        end
        LEX_COMMENT: if (ch == CH_STAR) lex_q = LEX_CSTAR;
        LEX_CSTAR: begin
          if (ch == CH_SLASH) lex_q = LEX_CODE;
          else if (ch != CH_STAR) lex_q = LEX_COMMENT;
        end
        default: lex_q = LEX_CODE;
      endcase
    end
    shown = int'(nest_q);
    if (w.done) begin
      lex_q      = LEX_CODE;
      nest_q     = '0;
      routines_q = '0;
    end
    if (shown > 127) shown = 127;
    if (shown < -128) shown = -128;
    w.level = shown[LEVEL_OUT_BITS-1:0];
    w.mode  = lex_q;
    return w;
  endfunction

  // Offer one word on the write port; record its expected result once taken.
  task automatic send_byte(input logic [7:0] ch, input logic typed, input lex_word_t want);
    lex_word_t got_pred;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push        <= 1'b1;
    text_byte_i <= ch;
    do @(posedge clk_i); while (full);
    got_pred = lex_predict(ch);
    pending_words.push_back(typed ? want : got_pred);
  endtask

  task automatic send_plain(input logic [7:0] ch);
    send_byte(ch, 1'b0, '0);
  endtask

  // Any byte but the end-of-text marker and one further byte to avoid.
  function automatic logic [7:0] body_byte(input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_END || b == avoid);
    return b;
  endfunction

  // Emit one fragment of C-like text; return how many words it took.
  task automatic send_fragment(output int used);
    int         pick;
    int         len;
    logic [7:0] q;
    pick = $urandom_range(99);
    used = 0;
    if (pick < 20) begin
      send_plain(CH_OPEN);
      used = 1;
    end else if (pick < 38) begin
      send_plain(CH_CLOSE);
      used = 1;
    end else if (pick < 50) begin
      // Quoted text, now and then left open.
      q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
      len = $urandom_range(6);
      send_plain(q);
      repeat (len) send_plain(body_byte(q));
      used = len + 1;
      if ($urandom_range(9) != 0) begin
        send_plain(q);
        used++;
      end
    end else if (pick < 62) begin
      // Comment with random body, stars in plenty, sometimes unterminated.
      len = $urandom_range(7);
      send_plain(CH_SLASH);
      send_plain(CH_STAR);
      repeat (len) send_plain($urandom_range(2) == 0 ? CH_STAR : body_byte(CH_SLASH));
      used = len + 2;
      if ($urandom_range(9) != 0) begin
        send_plain(CH_STAR);
        send_plain(CH_SLASH);
        used += 2;
      end
    end else if (pick < 70) begin
      // Lone slash followed by anything: brace, quote, slash or noise.
      send_plain(CH_SLASH);
      case ($urandom_range(3))
        0: send_plain(CH_OPEN);
        1: send_plain(CH_CLOSE);
        2: send_plain($urandom_range(1) ? CH_SQUOTE : CH_SLASH);
        default: send_plain(body_byte(CH_END));
      endcase
      used = 2;
    end else if (pick < 86) begin
      send_plain(body_byte(CH_END));
      used = 1;
    end else if (pick < 89) begin
      send_plain(CH_END);
      used = 1;
    end else begin
      send_plain(8'($urandom_range(8'h7E, 8'h20)));
      used = 1;
    end
  endtask

  // Random traffic of about the given number of words, under the current idling.
  task automatic send_random(input int words);
    int sent;
    int used;
    sent = 0;
    while (sent < words) begin
      send_fragment(used);
      sent += used;
    end
  endtask

  // Receiver: stall pop at random, one decision per falling edge.
  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Compare each word taken from the read port with the oldest prediction.
  always @(posedge clk_i) begin
    lex_word_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing outstanding");
        n_errors++;
      end else begin
        want = pending_words.pop_front();
        if (nest_level_o !== want.level) begin
          $error("nest_level: expected %0d, got %0d", want.level, nest_level_o);
          n_errors++;
        end
        if (lex_mode_o !== want.mode) begin
          $error("lex_mode: expected %0d, got %0d", want.mode, lex_mode_o);
          n_errors++;
        end
        if (routine_closed_o !== want.closed) begin
          $error("routine_closed: expected %0d, got %0d", want.closed, routine_closed_o);
          n_errors++;
        end
        if (text_done_o !== want.done) begin
          $error("text_done: expected %0d, got %0d", want.done, text_done_o);
          n_errors++;
        end
        if (balanced_o !== want.bal) begin
          $error("balanced: expected %0d, got %0d", want.bal, balanced_o);
          n_errors++;
        end
        if (routines_reported_o !== want.rep) begin
          $error("routines_reported: expected %0d, got %0d", want.rep, routines_reported_o);
          n_errors++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("** brace_nesting_lexer: FAILED **");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table, full speed on both sides.
    for (int i = 0; i < ROWS; i++) begin
      send_byte(text_rows[i].ch, text_rows[i].typed, text_rows[i].want);
    end

    // Level limits: nest past the top and end the text, then close past the bottom.
    repeat (2 ** (LEVEL_BITS - 1) + 2) send_plain(CH_OPEN);
    send_plain(CH_END);
    repeat (2 ** (LEVEL_BITS - 1) + 2) send_plain(CH_CLOSE);
    send_plain(CH_END);

    // Random text under each idling pattern.
    send_random(66);
    send_idle_pct = 78;
    send_random(66);
    send_idle_pct = 0;
    pop_stall_pct = 78;
    send_random(66);
    send_idle_pct = 26;
    pop_stall_pct = 26;
    send_random(66);

    @(negedge clk_i);
    push          <= 1'b0;
    pop_stall_pct = 0;
    while (pending_words.size() != 0) @(posedge clk_i);
    // Give any stray word time to surface through the pipeline.
    repeat (10) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("** brace_nesting_lexer: PASSED **");
    end else begin
      $display("** brace_nesting_lexer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== brace_nesting_lexer.f =====
hdl/blc_pkg.sv
hdl/blc_front.sv
hdl/blc_queue.sv
hdl/blc_back.sv
hdl/brace_nesting_lexer.sv
sim/testbench.sv
